>>> rtl/sgr_pkg.sv
// Shared types, constants and the 5x7 glyph table for the scaled glyph text renderer.
// No dependencies; every other file in rtl/ except sgr_checker refers to this package by scoped name.
`default_nettype none

package sgr_pkg;

    localparam int FRAME_WIDTH_DEF  = 160;
    localparam int FRAME_HEIGHT_DEF = 80;
    localparam int MAX_SCALE_DEF    = 4;

    localparam int POS_W        = 12;
    localparam int PIX_W        = 16;
    localparam int COORD_W      = 14;
    localparam int SCALE_W      = 4;
    localparam int OFF_W        = 6;
    localparam int CELL_ADVANCE = 6;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COUNT  = 36;
    localparam int GLYPH_BITS   = 40;
    localparam int DIGIT_COUNT  = 10;
    localparam int CURSOR_MAX   = 2047;
    localparam int CMDQ_DEPTH   = 2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5a;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // byte c holds glyph column c, bit r of it lights row r
    localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h3e_45_49_51_3e, 40'h00_40_7f_42_00, 40'h46_49_51_61_42, 40'h31_4b_45_41_21,
        40'h10_7f_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4a_3c, 40'h03_05_09_71_01,
        40'h36_49_49_49_36, 40'h1e_29_49_49_06, 40'h7e_11_11_11_7e, 40'h36_49_49_49_7f,
        40'h22_41_41_41_3e, 40'h1c_22_41_41_7f, 40'h41_49_49_49_7f, 40'h01_09_09_09_7f,
        40'h7a_49_49_41_3e, 40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h01_3f_41_40_20,
        40'h41_22_14_08_7f, 40'h40_40_40_40_7f, 40'h7f_02_0c_02_7f, 40'h7f_10_08_04_7f,
        40'h3e_41_41_41_3e, 40'h06_09_09_09_7f, 40'h5e_21_51_41_3e, 40'h46_29_19_09_7f,
        40'h31_49_49_49_46, 40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f,
        40'h3f_40_38_40_3f, 40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h43_45_49_51_61
    };

    typedef enum logic [1:0] {
        K_NONE,
        K_DRAW,
        K_READ,
        K_CLEAR
    } kind_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_DRAW,
        BK_CLEAR,
        BK_READ,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [GLYPH_BITS-1:0]     glyph;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [PIX_W-1:0]          word;
        logic [SCALE_W-1:0]        scale;
        logic signed [POS_W-1:0]   cursor;
        logic                      outside;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cmdq_status_t;

endpackage

`default_nettype wire

>>> rtl/sgr_front.sv
// Front end: takes command beats, tracks the text cursor, looks up glyphs, classifies.
// Depends on sgr_pkg; feeds sgr_cmdq.
`default_nettype none

module sgr_front #(
    parameter int FRAME_WIDTH  = sgr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgr_pkg::FRAME_HEIGHT_DEF,
    parameter int MAX_SCALE    = sgr_pkg::MAX_SCALE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [1:0]                        opcode,
    input  wire logic [7:0]                        char_code,
    input  wire logic                              start_of_text,
    input  wire logic signed [sgr_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [sgr_pkg::POS_W-1:0]  pos_y,
    input  wire logic [sgr_pkg::PIX_W-1:0]         ink_color,
    input  wire logic [2:0]                        magnify,
    input  wire sgr_pkg::cmdq_status_t             q_stat,
    input  wire logic                              init_busy,
    output      logic                              push,
    output      sgr_pkg::cmd_t                     cmd
);

    logic signed [sgr_pkg::POS_W-1:0] cursor_reg;
    logic signed [sgr_pkg::POS_W-1:0] cursor_next;

    logic [sgr_pkg::SCALE_W-1:0] mag_ext;
    logic [sgr_pkg::SCALE_W-1:0] scale;
    logic [sgr_pkg::POS_W-1:0]   base;
    logic [6:0]                  advance;
    logic [sgr_pkg::POS_W:0]     sum;
    logic [sgr_pkg::POS_W-1:0]   draw_next;
    logic                        is_digit;
    logic                        is_upper;
    logic [5:0]                  glyph_idx;
    logic                        rd_inside;

    assign busy = q_stat.full | init_busy;
    assign push = start & ~busy;

    assign mag_ext = sgr_pkg::SCALE_W'(magnify);

    always_comb
    begin
        if (mag_ext == '0)
            scale = sgr_pkg::SCALE_W'(1);
        else if (mag_ext > sgr_pkg::SCALE_W'(MAX_SCALE))
            scale = sgr_pkg::SCALE_W'(MAX_SCALE);
        else
            scale = mag_ext;
    end

    assign base    = start_of_text ? pos_x : cursor_reg;
    assign advance = 7'(sgr_pkg::CELL_ADVANCE) * 7'(scale);
    assign sum     = {base[sgr_pkg::POS_W-1], base} + (sgr_pkg::POS_W + 1)'(advance);
    // above the cursor limit exactly when the sum is non-negative with bit 11 set
    assign draw_next = (!sum[sgr_pkg::POS_W] && sum[sgr_pkg::POS_W-1]) ?
                       sgr_pkg::POS_W'(sgr_pkg::CURSOR_MAX) : sum[sgr_pkg::POS_W-1:0];

    assign is_digit = (char_code >= sgr_pkg::CHAR_ZERO) && (char_code <= sgr_pkg::CHAR_NINE);
    assign is_upper = (char_code >= sgr_pkg::CHAR_A) && (char_code <= sgr_pkg::CHAR_Z);

    always_comb
    begin
        if (is_digit)
            glyph_idx = 6'(char_code - sgr_pkg::CHAR_ZERO);
        else if (is_upper)
            glyph_idx = 6'(char_code - sgr_pkg::CHAR_A) + 6'(sgr_pkg::DIGIT_COUNT);
        else
            glyph_idx = '0;
    end

    assign rd_inside = !pos_x[sgr_pkg::POS_W-1] && !pos_y[sgr_pkg::POS_W-1]
                    && ($unsigned(pos_x) < sgr_pkg::POS_W'(FRAME_WIDTH))
                    && ($unsigned(pos_y) < sgr_pkg::POS_W'(FRAME_HEIGHT));

    always_comb
    begin
        cursor_next = cursor_reg;
        cmd.kind    = sgr_pkg::K_NONE;
        cmd.glyph   = sgr_pkg::GLYPH_ROM[glyph_idx];
        cmd.x       = pos_x;
        cmd.y       = pos_y;
        cmd.word    = {ink_color[7:0], ink_color[15:8]};
        cmd.scale   = scale;
        cmd.cursor  = cursor_reg;
        cmd.outside = 1'b0;
        unique case (opcode)
            sgr_pkg::OP_DRAW:
            begin
                cmd.kind    = (is_digit || is_upper) ? sgr_pkg::K_DRAW : sgr_pkg::K_NONE;
                cmd.x       = base;
                cmd.cursor  = draw_next;
                cursor_next = draw_next;
            end
            sgr_pkg::OP_READ:
            begin
                cmd.kind    = rd_inside ? sgr_pkg::K_READ : sgr_pkg::K_NONE;
                cmd.outside = !rd_inside;
            end
            sgr_pkg::OP_CLEAR:
            begin
                cmd.kind = sgr_pkg::K_CLEAR;
            end
            default:
            begin
                cmd.kind = sgr_pkg::K_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cursor_reg <= '0;
        else if (push)
            cursor_reg <= cursor_next;
    end

endmodule

`default_nettype wire

>>> rtl/sgr_cmdq.sv
// Two-entry command queue between the front end and the pixel engine.
// Depends on sgr_pkg for cmd_t and the status struct.
`default_nettype none

module sgr_cmdq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sgr_pkg::cmd_t         cmd_in,
    input  wire logic                  pop,
    output      sgr_pkg::cmd_t         cmd_out,
    output      sgr_pkg::cmdq_status_t q_stat
);

    localparam int PTR_W = $clog2(sgr_pkg::CMDQ_DEPTH);

    sgr_pkg::cmd_t      entry_reg [sgr_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    assign q_stat.full  = (count_reg == (PTR_W + 1)'(sgr_pkg::CMDQ_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign cmd_out      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

>>> rtl/sgr_back.sv
// Pixel engine: owns the frame store, sweeps it clear, paints glyph dots, reads pixels.
// Depends on sgr_pkg; takes commands from sgr_cmdq and drives the result beat.
`default_nettype none

module sgr_back #(
    parameter int FRAME_WIDTH  = sgr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgr_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sgr_pkg::cmdq_status_t             q_stat,
    input  wire sgr_pkg::cmd_t                     q_head,
    output      logic                              pop,
    output      logic                              init_busy,
    output      logic                              done,
    output      logic [sgr_pkg::PIX_W-1:0]         pixel_value,
    output      logic signed [sgr_pkg::POS_W-1:0]  next_cursor_x,
    output      logic                              outside_frame
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int X_W    = $clog2(FRAME_WIDTH);
    localparam int Y_W    = $clog2(FRAME_HEIGHT);
    localparam int CW     = sgr_pkg::COORD_W;
    localparam int SW     = sgr_pkg::SCALE_W;
    localparam int OW     = sgr_pkg::OFF_W;

    sgr_pkg::back_state_t state_reg;
    sgr_pkg::back_state_t state_next;
    sgr_pkg::cmd_t        cmd_reg;

    logic [sgr_pkg::PIX_W-1:0] mem [DEPTH];
    logic [sgr_pkg::PIX_W-1:0] rd_data_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic [2:0]        col_reg;
    logic [2:0]        col_next;
    logic [2:0]        row_reg;
    logic [2:0]        row_next;
    logic [SW-1:0]     dx_reg;
    logic [SW-1:0]     dx_next;
    logic [SW-1:0]     dy_reg;
    logic [SW-1:0]     dy_next;
    logic [OW-1:0]     cx_reg;
    logic [OW-1:0]     cx_next;
    logic [OW-1:0]     ry_reg;
    logic [OW-1:0]     ry_next;

    logic              pv_reg;
    logic              pv_next;
    logic [CW-1:0]     px_reg;
    logic [CW-1:0]     py_reg;

    logic              done_reg;
    logic [sgr_pkg::PIX_W-1:0]        pixel_reg;
    logic signed [sgr_pkg::POS_W-1:0] cursor_out_reg;
    logic              outside_reg;

    logic              sweep;
    logic              draw_step;
    logic              rd_en;
    logic              emit;
    logic              clr_last;
    logic              draw_last;
    logic              dy_end;
    logic              dx_end;
    logic              row_end;
    logic              col_end;
    logic [SW-1:0]     scale_m1;
    logic [CW-1:0]     px_calc;
    logic [CW-1:0]     py_calc;
    logic              in_frame;
    logic              lit;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [sgr_pkg::PIX_W-1:0] wr_data;

    assign clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    assign scale_m1  = cmd_reg.scale - 1'b1;
    assign dy_end    = (dy_reg == scale_m1);
    assign dx_end    = (dx_reg == scale_m1);
    assign row_end   = (row_reg == 3'(sgr_pkg::GLYPH_ROWS - 1));
    assign col_end   = (col_reg == 3'(sgr_pkg::GLYPH_COLS - 1));
    assign draw_last = dy_end && dx_end && row_end && col_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgr_pkg::BK_INIT:
                if (clr_last)
                    state_next = sgr_pkg::BK_IDLE;
            sgr_pkg::BK_IDLE:
                if (!q_stat.empty)
                begin
                    unique case (q_head.kind)
                        sgr_pkg::K_DRAW:  state_next = sgr_pkg::BK_DRAW;
                        sgr_pkg::K_READ:  state_next = sgr_pkg::BK_READ;
                        sgr_pkg::K_CLEAR: state_next = sgr_pkg::BK_CLEAR;
                        default:          state_next = sgr_pkg::BK_DONE;
                    endcase
                end
            sgr_pkg::BK_DRAW:
                if (draw_last)
                    state_next = sgr_pkg::BK_DONE;
            sgr_pkg::BK_CLEAR:
                if (clr_last)
                    state_next = sgr_pkg::BK_DONE;
            sgr_pkg::BK_READ:
                state_next = sgr_pkg::BK_DONE;
            sgr_pkg::BK_DONE:
                state_next = sgr_pkg::BK_IDLE;
            default:
                state_next = sgr_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop       = 1'b0;
        sweep     = 1'b0;
        draw_step = 1'b0;
        rd_en     = 1'b0;
        emit      = 1'b0;
        init_busy = 1'b0;
        unique case (state_reg)
            sgr_pkg::BK_INIT:
            begin
                sweep     = 1'b1;
                init_busy = 1'b1;
            end
            sgr_pkg::BK_IDLE:  pop       = !q_stat.empty;
            sgr_pkg::BK_DRAW:  draw_step = 1'b1;
            sgr_pkg::BK_CLEAR: sweep     = 1'b1;
            sgr_pkg::BK_READ:  rd_en     = 1'b1;
            sgr_pkg::BK_DONE:  emit      = 1'b1;
            default:           pop       = 1'b0;
        endcase
    end

    // dot walk: dy innermost, then dx, row, column
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        cx_next       = cx_reg;
        ry_next       = ry_reg;
        clr_addr_next = clr_addr_reg;
        if (sweep)
            clr_addr_next = clr_last ? '0 : clr_addr_reg + 1'b1;
        if (pop)
        begin
            col_next = '0;
            row_next = '0;
            dx_next  = '0;
            dy_next  = '0;
            cx_next  = '0;
            ry_next  = '0;
        end
        else if (draw_step)
        begin
            if (!dy_end)
                dy_next = dy_reg + 1'b1;
            else
            begin
                dy_next = '0;
                if (!dx_end)
                    dx_next = dx_reg + 1'b1;
                else
                begin
                    dx_next = '0;
                    if (!row_end)
                    begin
                        row_next = row_reg + 1'b1;
                        ry_next  = ry_reg + OW'(cmd_reg.scale);
                    end
                    else
                    begin
                        row_next = '0;
                        ry_next  = '0;
                        col_next = col_reg + 1'b1;
                        cx_next  = cx_reg + OW'(cmd_reg.scale);
                    end
                end
            end
        end
    end

    assign px_calc = {{(CW - sgr_pkg::POS_W){cmd_reg.x[sgr_pkg::POS_W-1]}}, cmd_reg.x}
                   + CW'(cx_reg) + CW'(dx_reg);
    assign py_calc = {{(CW - sgr_pkg::POS_W){cmd_reg.y[sgr_pkg::POS_W-1]}}, cmd_reg.y}
                   + CW'(ry_reg) + CW'(dy_reg);
    assign in_frame = !px_calc[CW-1] && !py_calc[CW-1]
                   && (px_calc < CW'(FRAME_WIDTH)) && (py_calc < CW'(FRAME_HEIGHT));
    assign lit      = cmd_reg.glyph[{col_reg, row_reg}];
    assign pv_next  = draw_step && lit && in_frame;

    assign draw_addr = ADDR_W'(py_reg[Y_W-1:0]) * ADDR_W'(FRAME_WIDTH)
                     + ADDR_W'(px_reg[X_W-1:0]);
    assign rd_addr   = ADDR_W'(cmd_reg.y[Y_W-1:0]) * ADDR_W'(FRAME_WIDTH)
                     + ADDR_W'(cmd_reg.x[X_W-1:0]);

    always_comb
    begin
        wr_en   = sweep | pv_reg;
        wr_addr = sweep ? clr_addr_reg : draw_addr;
        wr_data = sweep ? '0 : cmd_reg.word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sgr_pkg::BK_INIT;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            cx_reg       <= '0;
            ry_reg       <= '0;
            pv_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            cx_reg       <= cx_next;
            ry_reg       <= ry_next;
            pv_reg       <= pv_next;
            done_reg     <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= q_head;
        px_reg <= px_calc;
        py_reg <= py_calc;
        if (emit)
        begin
            pixel_reg      <= (cmd_reg.kind == sgr_pkg::K_READ) ? rd_data_reg : '0;
            cursor_out_reg <= cmd_reg.cursor;
            outside_reg    <= cmd_reg.outside;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign done          = done_reg;
    assign pixel_value   = pixel_reg;
    assign next_cursor_x = cursor_out_reg;
    assign outside_frame = outside_reg;

endmodule

`default_nettype wire

>>> rtl/scaled_glyph_text_renderer_unit.sv
// Top level of the scaled glyph text renderer: front end, command queue, pixel engine.
// Depends on sgr_pkg, sgr_front, sgr_cmdq and sgr_back.
//
// Usage: a command beat is taken on a rising edge with start high and busy low. Opcode
// selects draw character (at the text cursor, row pos_y), read pixel (pos_x, pos_y) or
// clear frame store. Every command gives one result beat: done is high for exactly one
// cycle with pixel_value, next_cursor_x and outside_frame; the receiver cannot stall it.
// Results come in command order. A two-entry queue lets up to two commands wait behind
// the one in progress; busy is high while it is full.
// The pixel engine works on one command at a time while the queue takes new ones until full.
// A drawn glyph at scale s steps through each dot of the 5x7 cell s * s times and writes
// the store only where the dot is lit and inside the frame; a read inside the frame reads
// one store word; a clear sweeps the store one word per cycle; other commands go straight
// to their result beat.
// Reset clears the cursor and then sweeps the frame store to zero, one word per cycle;
// busy is high throughout that sweep.
`default_nettype none

module scaled_glyph_text_renderer_unit #(
    parameter int FRAME_WIDTH  = sgr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sgr_pkg::FRAME_HEIGHT_DEF,
    parameter int MAX_SCALE    = sgr_pkg::MAX_SCALE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [1:0]                        opcode,
    input  wire logic [7:0]                        char_code,
    input  wire logic                              start_of_text,
    input  wire logic signed [sgr_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [sgr_pkg::POS_W-1:0]  pos_y,
    input  wire logic [sgr_pkg::PIX_W-1:0]         ink_color,
    input  wire logic [2:0]                        magnify,
    output      logic                              done,
    output      logic [sgr_pkg::PIX_W-1:0]         pixel_value,
    output      logic signed [sgr_pkg::POS_W-1:0]  next_cursor_x,
    output      logic                              outside_frame
);

    sgr_pkg::cmdq_status_t q_stat;
    sgr_pkg::cmd_t         cmd_in;
    sgr_pkg::cmd_t         q_head;
    logic                  push;
    logic                  pop;
    logic                  init_busy;

    sgr_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .MAX_SCALE    (MAX_SCALE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .char_code     (char_code),
        .start_of_text (start_of_text),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .ink_color     (ink_color),
        .magnify       (magnify),
        .q_stat        (q_stat),
        .init_busy     (init_busy),
        .push          (push),
        .cmd           (cmd_in)
    );

    sgr_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (q_head),
        .q_stat  (q_stat)
    );

    sgr_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_head        (q_head),
        .pop           (pop),
        .init_busy     (init_busy),
        .done          (done),
        .pixel_value   (pixel_value),
        .next_cursor_x (next_cursor_x),
        .outside_frame (outside_frame)
    );

endmodule

`default_nettype wire

>>> rtl/sgr_checker.sv
// Port-level checks for the scaled glyph text renderer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module sgr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [15:0] pixel_value,
    input wire logic        outside_frame
);

    // a result beat is never followed directly by another
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outside_frame) |-> (pixel_value == 16'h0000))
        else $error("outside read returned a pixel");

    // store sweep after reset holds off commands
    a_reset_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
        else $error("not busy after reset");

endmodule

bind scaled_glyph_text_renderer_unit sgr_checker u_sgr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .pixel_value   (pixel_value),
    .outside_frame (outside_frame)
);

`default_nettype wire
